### src/dqrb_pkg.sv
// ----------------------------------------------------------------------------
// dqrb_pkg
// Shared sizes, command and status codes, and a helper for the ring-buffer
// double-ended queue.
// ----------------------------------------------------------------------------
package dqrb_pkg;

    // Storage geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the command to the store and pointers
        logic read;   // fetch front and back after the update
    } t_dp_cmd;

    // Fold a position below twice the depth back into the store
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] pos);
        logic [IDX_W:0] folded;
        folded = pos;
        if (pos >= (IDX_W+1)'(DEPTH)) begin
            folded = pos - (IDX_W+1)'(DEPTH);
        end
        return folded[IDX_W-1:0];
    endfunction

endpackage

### src/dqrb_ifs.sv
// ----------------------------------------------------------------------------
// dqrb_ifs
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface dqrb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [dqrb_pkg::CMD_W-1:0]          cmd;
    logic signed [dqrb_pkg::DATA_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dqrb_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [dqrb_pkg::DATA_W-1:0]  popped_value;
    logic [dqrb_pkg::STAT_W-1:0]         status;
    logic signed [dqrb_pkg::DATA_W-1:0]  front_value;
    logic signed [dqrb_pkg::DATA_W-1:0]  back_value;
    logic [dqrb_pkg::CNT_W-1:0]          entry_count;

    modport source (output valid, output popped_value, output status,
                    output front_value, output back_value, output entry_count,
                    input ready);
    modport sink   (input valid, input popped_value, input status,
                    input front_value, input back_value, input entry_count,
                    output ready);
endinterface

### src/dqrb_ctrl.sv
// ----------------------------------------------------------------------------
// dqrb_ctrl
// Sequencer: accept an item, apply it, read back front and back, offer result.
// ----------------------------------------------------------------------------
module dqrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dqrb_pkg::t_dp_cmd o_dp_cmd
);
    import dqrb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_EXEC;
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath commands
    always_comb begin
        o_dp_cmd      = '0;
        o_dp_cmd.load = in_acc;
        o_dp_cmd.exec = (r_state == S_EXEC);
        o_dp_cmd.read = (r_state == S_READ);
    end

    // An accepted item is always applied in the following cycle
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_dp_cmd.exec)
        else $error("accepted item not applied");

    // A result waits until taken and no new item enters meanwhile
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && !o_in_ready)
        else $error("result dropped while stalled");

    // The store is read back in the cycle after the update
    a_exec_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.exec |=> o_dp_cmd.read)
        else $error("read-back missing after update");

endmodule

### src/dqrb_dpath.sv
// ----------------------------------------------------------------------------
// dqrb_dpath
// Circular entry store with head index and entry count, plus result registers.
// ----------------------------------------------------------------------------
module dqrb_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dqrb_pkg::t_dp_cmd                   i_dp_cmd,
    input  logic [dqrb_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [dqrb_pkg::DATA_W-1:0]  i_value,
    output logic signed [dqrb_pkg::DATA_W-1:0]  o_popped_value,
    output logic [dqrb_pkg::STAT_W-1:0]         o_status,
    output logic signed [dqrb_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [dqrb_pkg::DATA_W-1:0]  o_back_value,
    output logic [dqrb_pkg::CNT_W-1:0]          o_entry_count
);
    import dqrb_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic              r_pop_ok;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    logic             full;
    logic             empty;
    logic [IDX_W:0]   head_x;
    logic [IDX_W:0]   count_x;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] last_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_a_addr;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
    end

    // Index arithmetic around the ring
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign head_x   = {1'b0, r_head};
    assign count_x  = (IDX_W+1)'(r_count);
    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = wrap_idx(head_x + 1'b1);
    assign tail_idx = wrap_idx(head_x + count_x);
    assign last_idx = wrap_idx(head_x + count_x - 1'b1);

    // Store write for pushes
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = tail_idx;
        case (r_cmd)
            CMD_PUSH_FRONT: begin
                wr_en   = !full;
                wr_addr = head_dec;
            end
            CMD_PUSH_BACK: begin
                wr_en   = !full;
                wr_addr = tail_idx;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Port A fetches the popped entry during the update, the front afterwards
    assign rd_a_addr = (i_dp_cmd.exec && r_cmd == CMD_POP_BACK) ? last_idx : r_head;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_dp_cmd.exec || i_dp_cmd.read) begin
            r_rd_a <= r_mem[rd_a_addr];
            r_rd_b <= r_mem[last_idx];
        end
    end

    // Pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_dp_cmd.exec) begin
            case (r_cmd)
                CMD_PUSH_FRONT: if (!full) begin
                    r_head  <= head_dec;
                    r_count <= r_count + 1'b1;
                end
                CMD_PUSH_BACK: if (!full) begin
                    r_count <= r_count + 1'b1;
                end
                CMD_POP_FRONT: if (!empty) begin
                    r_head  <= head_inc;
                    r_count <= r_count - 1'b1;
                end
                CMD_POP_BACK: if (!empty) begin
                    r_count <= r_count - 1'b1;
                end
                CMD_CLEAR: begin
                    r_head  <= '0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // Status and pop flag
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    r_status <= full ? ST_FULL : ST_OK;
                    r_pop_ok <= 1'b0;
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    r_status <= empty ? ST_EMPTY : ST_OK;
                    r_pop_ok <= !empty;
                end
                default: begin
                    r_status <= ST_OK;
                    r_pop_ok <= 1'b0;
                end
            endcase
        end
    end

    // Popped entry sits in port A after the update until the read-back copies it
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.read) begin
            r_popped <= r_pop_ok ? r_rd_a : '0;
        end
    end

    // Result fields
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = r_count;
    assign o_front_value  = empty ? '0 : r_rd_a;
    assign o_back_value   = empty ? '0 : r_rd_b;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_dp_cmd.exec |=> $stable(r_count) && $stable(r_head))
        else $error("pointers moved outside an update");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.exec && full
            && (r_cmd == CMD_PUSH_FRONT || r_cmd == CMD_PUSH_BACK)
        |=> r_status == ST_FULL && $stable(r_count) && $stable(r_head))
        else $error("push on full queue changed state");

endmodule

### src/deque_ring_buffer.sv
// ----------------------------------------------------------------------------
// deque_ring_buffer
// Bounded double-ended queue of signed 32-bit values in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd_ch carries one command item (cmd, value): push front, push back,
//   pop front, pop back or clear. o_res_ch returns exactly one result item
//   per command: popped value, status (ok, empty on pop, full on push) and
//   the front, back and entry count after the command.
//   Sequence: the command register, the ring-store update and the
//   registered read-back of front and back come in that order, and the
//   result is then offered.
//   Only one command is in flight; i_cmd_ch.ready is low from acceptance
//   until its result has been taken.
//   When the receiver stalls, the result holds steady on o_res_ch and no new
//   command is accepted.
//   Reset empties the queue (head and count to zero) and returns the
//   sequencer to idle; store contents are left as they were and are never
//   read before being written. Pop on empty and push on full leave the
//   queue unchanged and only report the status.
// ----------------------------------------------------------------------------
module deque_ring_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqrb_cmd_if.sink   i_cmd_ch,
    dqrb_res_if.source o_res_ch
);
    import dqrb_pkg::*;

    t_dp_cmd dp_cmd;

    dqrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .o_dp_cmd    (dp_cmd)
    );

    dqrb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_cmd          (i_cmd_ch.cmd),
        .i_value        (i_cmd_ch.value),
        .o_popped_value (o_res_ch.popped_value),
        .o_status       (o_res_ch.status),
        .o_front_value  (o_res_ch.front_value),
        .o_back_value   (o_res_ch.back_value),
        .o_entry_count  (o_res_ch.entry_count)
    );

endmodule
